@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL of the stack block, included by the datapath module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bsbi_pkg.sv @@
// Shared constants and types of the bounded stack with bottom increment.
package bsbi_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 11;
  localparam int WORD_W = 32;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_INC  = 2'd2;

  localparam logic [CNT_W-1:0]  MAX_SIZE_RESET = 11'd1024;
  localparam logic [WORD_W-1:0] EMPTY_WORD     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_pending;
    logic out_free;
  } ctrl_status_t;

endpackage

@@ hdl/bsbi_ctrl.sv @@
// Controller state machine sequencing the accept and execute phases of each item.
module bsbi_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bsbi_pkg::ctrl_status_t status,
  output bsbi_pkg::ctrl_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    in_ready = (state == ST_IDLE);
    cmd.load = in_valid && (state == ST_IDLE);
    cmd.exec = (state == ST_EXEC) && (!status.pop_pending || status.out_free);
    case (state)
      ST_IDLE: begin
        state_next = in_valid ? ST_EXEC : ST_IDLE;
      end
      ST_EXEC: begin
        state_next = cmd.exec ? ST_IDLE : ST_EXEC;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/bsbi_datapath.sv @@
// Datapath holding the element and lazy increment memories, the count and the result register.
`include "assert_macros.svh"

module bsbi_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bsbi_pkg::ctrl_cmd_t                  cmd,
  output bsbi_pkg::ctrl_status_t               status,
  input  logic                                 cfg_wr_en,
  input  logic        [bsbi_pkg::CNT_W-1:0]    cfg_wr_data,
  input  logic        [bsbi_pkg::OP_W-1:0]     op,
  input  logic signed [bsbi_pkg::WORD_W-1:0]   value,
  input  logic        [bsbi_pkg::CNT_W-1:0]    count_k,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [bsbi_pkg::WORD_W-1:0]   pop_value,
  output logic                                 pop_empty
);

  logic [bsbi_pkg::WORD_W-1:0] val_mem [bsbi_pkg::DEPTH];
  logic [bsbi_pkg::WORD_W-1:0] inc_mem [bsbi_pkg::DEPTH];

  logic [bsbi_pkg::CNT_W-1:0]  max_size;
  logic [bsbi_pkg::CNT_W-1:0]  count;
  logic [bsbi_pkg::CNT_W-1:0]  count_next;
  logic [bsbi_pkg::CNT_W-1:0]  cap;
  logic [bsbi_pkg::CNT_W-1:0]  lim;
  logic [bsbi_pkg::CNT_W-1:0]  count_m1;
  logic [bsbi_pkg::CNT_W-1:0]  count_m2;
  logic [bsbi_pkg::CNT_W-1:0]  lim_m1;
  logic [bsbi_pkg::ADDR_W-1:0] addr_a;
  logic [bsbi_pkg::ADDR_W-1:0] addr_b;
  logic                        wb_en_next;

  logic [bsbi_pkg::OP_W-1:0]   op_q;
  logic [bsbi_pkg::WORD_W-1:0] val_q;
  logic [bsbi_pkg::ADDR_W-1:0] wb_addr_q;
  logic                        wb_en_q;
  logic                        empty_q;
  logic                        can_push_q;
  logic [bsbi_pkg::WORD_W-1:0] val_rd;
  logic [bsbi_pkg::WORD_W-1:0] inca_rd;
  logic [bsbi_pkg::WORD_W-1:0] incb_rd;

  logic                        push_do;
  logic                        pop_do;
  logic                        inc_we;
  logic [bsbi_pkg::ADDR_W-1:0] inc_waddr;
  logic [bsbi_pkg::WORD_W-1:0] inc_wdata;

  always_comb begin
    cap = (max_size < bsbi_pkg::CNT_W'(bsbi_pkg::DEPTH)) ? max_size :
          bsbi_pkg::CNT_W'(bsbi_pkg::DEPTH);
    lim        = (count_k < count) ? count_k : count;
    count_m1   = count - bsbi_pkg::CNT_W'(1);
    count_m2   = count - bsbi_pkg::CNT_W'(2);
    lim_m1     = lim - bsbi_pkg::CNT_W'(1);
    addr_a     = count_m1[bsbi_pkg::ADDR_W-1:0];
    addr_b     = (op == bsbi_pkg::OP_INC) ? lim_m1[bsbi_pkg::ADDR_W-1:0] :
                 count_m2[bsbi_pkg::ADDR_W-1:0];
    wb_en_next = (op == bsbi_pkg::OP_INC) ? (lim != '0) :
                 (count >= bsbi_pkg::CNT_W'(2));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= op;
      val_q      <= value;
      wb_addr_q  <= addr_b;
      wb_en_q    <= wb_en_next;
      empty_q    <= (count == '0);
      can_push_q <= (count < cap);
    end
  end

  always_comb begin
    push_do   = cmd.exec && (op_q == bsbi_pkg::OP_PUSH) && can_push_q;
    pop_do    = cmd.exec && (op_q == bsbi_pkg::OP_POP);
    inc_we    = 1'b0;
    inc_waddr = wb_addr_q;
    inc_wdata = incb_rd + inca_rd;
    case (op_q)
      bsbi_pkg::OP_PUSH: begin
        inc_we    = push_do;
        inc_waddr = count[bsbi_pkg::ADDR_W-1:0];
        inc_wdata = '0;
      end
      bsbi_pkg::OP_POP: begin
        inc_we    = pop_do && wb_en_q;
        inc_wdata = incb_rd + inca_rd;
      end
      bsbi_pkg::OP_INC: begin
        inc_we    = cmd.exec && wb_en_q;
        inc_wdata = incb_rd + val_q;
      end
      default: begin
        inc_we = 1'b0;
      end
    endcase
  end

  // Each entry keeps the amount still owed to it and to every entry below it.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_rd  <= val_mem[addr_a];
      inca_rd <= inc_mem[addr_a];
      incb_rd <= inc_mem[addr_b];
    end
    if (push_do) begin
      val_mem[count[bsbi_pkg::ADDR_W-1:0]] <= val_q;
    end
    if (inc_we) begin
      inc_mem[inc_waddr] <= inc_wdata;
    end
  end

  always_comb begin
    count_next = count;
    if (push_do) begin
      count_next = count + bsbi_pkg::CNT_W'(1);
    end else if (pop_do && !empty_q) begin
      count_next = count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= bsbi_pkg::MAX_SIZE_RESET;
      count    <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_size <= cfg_wr_data;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_do) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_do) begin
      pop_value <= empty_q ? bsbi_pkg::EMPTY_WORD : (val_rd + inca_rd);
      pop_empty <= empty_q;
    end
  end

  always_comb begin
    status.pop_pending = (op_q == bsbi_pkg::OP_POP);
    status.out_free    = !out_valid || out_ready;
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= bsbi_pkg::CNT_W'(bsbi_pkg::DEPTH), "count exceeds depth")
  `ASSERT_IMPLIES(a_pop_room, clk, rst, pop_do, !out_valid || out_ready, "pop result overwrites a waiting result")
  `ASSERT_NEXT(a_pop_dec, clk, rst, pop_do && !empty_q, count == $past(count) - bsbi_pkg::CNT_W'(1), "pop did not decrement count")
  `ASSERT_NEXT(a_full_push, clk, rst, cmd.exec && (op_q == bsbi_pkg::OP_PUSH) && !can_push_q, $stable(count), "push onto a full stack changed count")

endmodule

@@ hdl/bounded_stack_with_bottom_increment.sv @@
// Top level of the bounded stack with bottom increment.
// Each item is first accepted, which reads the memories, and then written back.
// A new item is accepted only once the previous one has written back, set by the read then
// write of the increment memory; a pop result is registered when its write-back executes.
// A pop waits in its write-back cycle only while an earlier result has not been taken.
// Reset empties the stack and sets max_size to 1024; the memories need no clearing pass.
module bounded_stack_with_bottom_increment (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic        [bsbi_pkg::CNT_W-1:0]    cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [bsbi_pkg::OP_W-1:0]     op,
  input  logic signed [bsbi_pkg::WORD_W-1:0]   value,
  input  logic        [bsbi_pkg::CNT_W-1:0]    count_k,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bsbi_pkg::WORD_W-1:0]   pop_value,
  output logic                                 pop_empty
);

  bsbi_pkg::ctrl_cmd_t    cmd;
  bsbi_pkg::ctrl_status_t status;

  bsbi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bsbi_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op          (op),
    .value       (value),
    .count_k     (count_k),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .pop_value   (pop_value),
    .pop_empty   (pop_empty)
  );

endmodule
